>>> hw/rtl/hil_pkg.sv
// hil_pkg: constants, register indexes and FSM codes for the hash index
// log insert block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hil_pkg;

  localparam int NUM_BUCKETS_DEF = 1024;
  localparam int LOG_BITS_DEF    = 40;

  localparam int VALUE_BYTES     = 32;
  localparam int MAX_VALUE_BYTES = 46;

  localparam int SLOTS       = 8;
  localparam int SLOT_IDX_W  = 3;
  localparam int TAG_W       = 16;
  localparam int KEY_BYTES   = 16;
  localparam int HDR_BYTES   = 2;
  localparam int WRAP_SLACK  = 32;
  localparam int ALIGN       = 8;
  localparam int ENTRY_BYTES = KEY_BYTES + HDR_BYTES + VALUE_BYTES;
  localparam int ENTRY_ROUND = ENTRY_BYTES + ALIGN - 1;
  localparam int WRAP_LIMIT  = MAX_VALUE_BYTES + WRAP_SLACK;

  localparam int LOG_EXP_MIN = 12;
  localparam int LOG_EXP_MAX = 30;

  localparam int MASK_W   = 10;
  localparam int EXP_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int HASH_W   = 32;
  localparam int OFFSET_W = 40;
  localparam int ADDR_W   = 30;

  localparam logic [MASK_W-1:0] MASK_RESET = 10'd1023;
  localparam logic [EXP_W-1:0]  EXP_RESET  = 5'd24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUCKET_MASK  = 1'b0,
    REG_LOG_SIZE_EXP = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/hash_index_log_insert.sv
// Hash index insert with circular log head: top level.
// Depends on hil_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Each request names a bucket and a 16-bit tag; the block picks one of the
// bucket's 8 slots (highest matching or unused slot, else slot tag mod 8 is
// evicted), records tag and log head in it, and advances the log head by the
// entry length rounded to 8 bytes, jumping to the next lap when the room left
// is too small. A request first reads the bucket row from the synchronous
// slot memory, then updates it, writes it back and advances the head. A
// result waits in an output register; while it is stalled no request is
// taken, and the next request can be taken in the cycle the result leaves.
// After reset the slot memory is cleared one bucket per cycle, covering all
// NUM_BUCKETS buckets (1024 by default); no request is taken meanwhile,
// configuration writes are.
module hash_index_log_insert #(
  parameter int NUM_BUCKETS = hil_pkg::NUM_BUCKETS_DEF,
  parameter int LOG_BITS    = hil_pkg::LOG_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [hil_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hil_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire logic [hil_pkg::HASH_W-1:0]      bucket_hash,
  input  wire logic [hil_pkg::TAG_W-1:0]       key_tag,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output logic [hil_pkg::SLOT_IDX_W-1:0]       slot_used,
  output logic                                 evicted,
  output logic [hil_pkg::OFFSET_W-1:0]         entry_offset,
  output logic [hil_pkg::ADDR_W-1:0]           write_address,
  output logic                                 wrapped
);
  import hil_pkg::*;

  localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SW    = 1 + TAG_W + LOG_BITS;
  localparam int ROW_W = SLOTS * SW;
  localparam int CW    = (LOG_BITS > 31) ? LOG_BITS : 31;

  state_t state;

  logic [MASK_W-1:0]   bucket_mask;
  logic [EXP_W-1:0]    log_size_exp;
  logic [BW-1:0]       clr_cnt;
  logic [LOG_BITS-1:0] vhead;
  logic [LOG_BITS-1:0] head_rnd;
  logic [BW-1:0]       bkt;
  logic [TAG_W-1:0]    tag;

  logic [ROW_W-1:0] mem [NUM_BUCKETS];
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] wr_row;
  logic [BW-1:0]    waddr;
  logic [ROW_W-1:0] wdata;
  logic             we;

  logic               accept;
  logic [HASH_W-1:0]  bkt_full;
  logic [BW-1:0]      bkt_in;
  logic [EXP_W-1:0]   exp_c;
  logic [CW-1:0]      cap;
  logic [CW-1:0]      lmask;
  logic [CW-1:0]      head_x;
  logic [CW-1:0]      old_x;
  logic [CW-1:0]      room;
  logic [CW-1:0]      jump;
  logic [CW-1:0]      phys_old;
  logic               wrap;
  logic [LOG_BITS-1:0] head_next;
  logic [63:0]         old_64;
  logic [SLOT_IDX_W-1:0] chosen;
  logic                  found;
  logic [SW-1:0]         slot;
  logic [SW-1:0]         new_slot;

  assign accept    = req_valid && !req_stall;
  assign req_stall = !((state == ST_IDLE) && (!rsp_valid || !rsp_stall));
  assign bkt_full  = bucket_hash & {{(HASH_W-MASK_W){1'b0}}, bucket_mask};
  assign bkt_in    = bkt_full[BW-1:0];

  always_comb begin
    if (log_size_exp < EXP_W'(LOG_EXP_MIN)) begin
      exp_c = EXP_W'(LOG_EXP_MIN);
    end else if (log_size_exp > EXP_W'(LOG_EXP_MAX)) begin
      exp_c = EXP_W'(LOG_EXP_MAX);
    end else begin
      exp_c = log_size_exp;
    end
  end

  assign cap      = CW'(1) << exp_c;
  assign lmask    = cap - CW'(1);
  assign head_x   = CW'(head_rnd);
  assign old_x    = CW'(vhead);
  assign room     = cap - (head_x & lmask);
  assign wrap     = room <= CW'(WRAP_LIMIT);
  assign jump     = (head_x + cap) & ~lmask;
  assign head_next = wrap ? jump[LOG_BITS-1:0] : head_rnd;
  assign phys_old = old_x & lmask;
  assign old_64   = 64'(vhead);

  // highest slot that is unused or already holds the tag
  always_comb begin
    chosen = tag[SLOT_IDX_W-1:0];
    found  = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      slot = rd_row[i*SW +: SW];
      if (!slot[SW-1] || (slot[SW-2 -: TAG_W] == tag)) begin
        chosen = SLOT_IDX_W'(i);
        found  = 1'b1;
      end
    end
  end

  assign new_slot = {1'b1, tag, vhead};

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      wr_row[i*SW +: SW] = (chosen == SLOT_IDX_W'(i)) ? new_slot : rd_row[i*SW +: SW];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = bkt;
    wdata = wr_row;
    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = '0;
      end
      ST_LOOKUP: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (accept) begin
      rd_row <= mem[bkt_in];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_mask  <= MASK_RESET;
      log_size_exp <= EXP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BUCKET_MASK:  bucket_mask  <= cfg_data[MASK_W-1:0];
        REG_LOG_SIZE_EXP: log_size_exp <= cfg_data[EXP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      vhead     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + BW'(1);
          if (clr_cnt == BW'(NUM_BUCKETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          vhead     <= head_next;
          rsp_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bkt      <= bkt_in;
      tag      <= key_tag;
      head_rnd <= (vhead + LOG_BITS'(ENTRY_ROUND)) & ~LOG_BITS'(ALIGN - 1);
    end
    if (state == ST_LOOKUP) begin
      slot_used     <= chosen;
      evicted       <= !found;
      entry_offset  <= old_64[OFFSET_W-1:0];
      write_address <= phys_old[ADDR_W-1:0];
      wrapped       <= wrap;
    end
  end

endmodule

`default_nettype wire
